// ===== hw/rtl/anp_pkg.sv =====
// Package for the ASCII number parser: sizes, codes, the item and
// configuration structures, and the character helpers. No dependencies.
package anp_pkg;

	localparam int MAX_FIELD_LEN = 23;
	localparam int CNT_W         = $clog2(MAX_FIELD_LEN + 1);
	localparam int CONSUMED_W    = 5;
	localparam int VALUE_W       = 64;
	localparam int STATUS_W      = 3;
	localparam int RADIX_W       = 6;
	localparam int REG_IDX_W     = 3;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

	localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
	localparam logic [RADIX_W-1:0] RADIX_ONE  = 6'd1;
	localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
	localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;
	localparam logic [RADIX_W-1:0] RADIX_TOP  = 6'd36;
	localparam logic [RADIX_W-1:0] DIGIT_NONE = 6'd63;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RADIX      = 3'd0,
		REG_SIGNED     = 3'd1,
		REG_WIDTH      = 3'd2,
		REG_STRICT     = 3'd3,
		REG_BOUNDS_EN  = 3'd4,
		REG_BOUND_MIN  = 3'd5,
		REG_BOUND_MAX  = 3'd6
	} reg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_NO_NUM   = 3'd1,
		ST_OVERFLOW = 3'd2,
		ST_TRAILING = 3'd3,
		ST_TOO_LONG = 3'd4,
		ST_RANGE    = 3'd5
	} status_t;

	typedef enum logic [5:0] {
		PH_WS     = 6'b000001,
		PH_SIGN   = 6'b000010,
		PH_ZERO   = 6'b000100,
		PH_ZEROX  = 6'b001000,
		PH_DIGITS = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	localparam logic [1:0] WSEL_8  = 2'd0;
	localparam logic [1:0] WSEL_16 = 2'd1;
	localparam logic [1:0] WSEL_32 = 2'd2;

	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		logic               signed_mode;
		logic [1:0]         width_select;
		logic               strict_mode;
		logic               bounds_enable;
		logic [VALUE_W-1:0] bound_min;
		logic [VALUE_W-1:0] bound_max;
	} cfg_t;

	typedef struct packed {
		logic               last;
		logic               over;
		logic               first;
		logic [RADIX_W-1:0] radix;
		logic [RADIX_W-1:0] digit;
		logic               ws;
		logic               sign;
		logic               minus;
		logic               zero;
		logic               x;
		logic               nul;
		logic [CNT_W-1:0]   pos;
	} entry_t;

	typedef struct packed {
		logic [VALUE_W-1:0] acc;
		logic               zerox;
		logic               neg;
		logic               ovf;
		logic [RADIX_W-1:0] rad;
		logic [CNT_W-1:0]   cons;
		logic               seen;
		logic               trail;
		logic               too_long;
	} snap_t;

	function automatic logic [RADIX_W-1:0] digit_of(input logic [7:0] c);
		logic [RADIX_W-1:0] d;
		d = DIGIT_NONE;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = RADIX_W'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			d = RADIX_W'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h5a) begin
			d = RADIX_W'(c - 8'h37);
		end
		return d;
	endfunction

	function automatic logic radix_bad(input logic [RADIX_W-1:0] r);
		return (r == RADIX_ONE) || (r > RADIX_TOP);
	endfunction

endpackage

// ===== hw/rtl/anp_if.sv =====
// Channel interfaces of the ASCII number parser: text bytes, results and
// configuration writes. Depends on anp_pkg.
interface anp_byte_if;
	import anp_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       is_last;
	modport source(output valid, text_byte, is_last, input ready);
	modport sink(input valid, text_byte, is_last, output ready);
endinterface

interface anp_result_if;
	import anp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [VALUE_W-1:0]    value;
	logic [CONSUMED_W-1:0] consumed;
	logic [STATUS_W-1:0]   status;
	modport source(output valid, value, consumed, status, input ready);
	modport sink(input valid, value, consumed, status, output ready);
endinterface

interface anp_cfg_if;
	import anp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [VALUE_W-1:0]   data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/anp_front.sv =====
// Front end: accepts text bytes, counts the field and classifies each byte
// into a queue entry. Depends on anp_pkg and anp_if.
module anp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	anp_byte_if.sink                     text,
	input  logic [anp_pkg::RADIX_W-1:0]  radix,
	input  logic                         q_full,
	output logic                         push,
	output anp_pkg::entry_t              entry
);
	import anp_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             over;

	assign text.ready = !q_full;
	assign push       = text.valid && text.ready;
	assign over       = (count_q >= CNT_W'(MAX_FIELD_LEN));

	always_comb begin
		entry.last  = text.is_last;
		entry.over  = over;
		entry.first = (count_q == '0);
		entry.radix = radix;
		entry.digit = digit_of(text.text_byte);
		entry.ws    = (text.text_byte == 8'h20) ||
			(text.text_byte >= 8'h09 && text.text_byte <= 8'h0d);
		entry.sign  = (text.text_byte == 8'h2b) || (text.text_byte == 8'h2d);
		entry.minus = (text.text_byte == 8'h2d);
		entry.zero  = (text.text_byte == 8'h30);
		entry.x     = (text.text_byte == 8'h78) || (text.text_byte == 8'h58);
		entry.nul   = (text.text_byte == 8'h00);
		entry.pos   = count_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			if (text.is_last) begin
				count_q <= '0;
			end else if (!over) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/anp_queue.sv =====
// Short queue of classified entries between the front and back ends.
// Depends on anp_pkg.
module anp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  anp_pkg::entry_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            rvalid,
	output anp_pkg::entry_t rdata
);
	import anp_pkg::*;

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign full   = (fill_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign rvalid = (fill_q != '0);
	assign rdata  = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			case ({push, pop})
				2'b10: fill_q <= fill_q + 1'b1;
				2'b01: fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/anp_back.sv =====
// Back end: runs the parse state machine with the multiply-accumulate, then
// two stages work out value, status and the range checks. Depends on anp_pkg and anp_if.
module anp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  anp_pkg::cfg_t   cfg,
	input  logic            q_valid,
	input  anp_pkg::entry_t e,
	output logic            pop,
	anp_result_if.source    result
);
	import anp_pkg::*;

	logic [VALUE_W-1:0] acc_q;
	phase_t             phase_q;
	logic               neg_q;
	logic               ovf_q;
	logic [RADIX_W-1:0] rad_q;
	logic [CNT_W-1:0]   cons_q;
	logic               seen_q;
	logic               trail_q;
	logic               long_q;

	snap_t              nxt;
	phase_t             nxt_phase;
	logic [RADIX_W-1:0] rad_cur;
	logic [RADIX_W-1:0] rad_start;
	logic [69:0]        prod;
	logic [70:0]        sum;
	logic               take;
	logic               start;

	snap_t              snap_s1;
	logic               v_s1;
	logic [VALUE_W-1:0] val_s2;
	logic [CNT_W-1:0]   cons_s2;
	status_t            st_s2;
	logic               chk_s2;
	logic               v_s2;
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [CNT_W-1:0]   out_cons_q;
	status_t            out_st_q;

	logic en_out, en_s2, en_s1;

	assign en_out = !out_valid_q || result.ready;
	assign en_s2  = !v_s2 || en_out;
	assign en_s1  = !v_s1 || en_s2;
	assign pop    = q_valid && en_s1;

	assign rad_cur   = e.first ? e.radix : rad_q;
	assign rad_start = (rad_cur == RADIX_AUTO) ? RADIX_DEC : rad_cur;
	assign prod      = 70'(acc_q) * 70'(rad_cur);
	assign sum       = 71'(prod) + 71'(e.digit);

	always_comb begin
		nxt.acc      = acc_q;
		nxt.neg      = neg_q;
		nxt.ovf      = ovf_q;
		nxt.rad      = rad_cur;
		nxt.cons     = cons_q;
		nxt.seen     = seen_q;
		nxt.trail    = trail_q;
		nxt.too_long = long_q;
		nxt_phase    = phase_q;
		take         = 1'b0;
		start        = 1'b0;

		if (e.over) begin
			nxt.too_long = 1'b1;
		end else begin
			case (phase_q)
				PH_WS: begin
					if (e.sign) begin
						nxt.neg   = e.minus;
						nxt_phase = PH_SIGN;
					end else if (!e.ws) begin
						start = 1'b1;
					end
				end
				PH_SIGN: begin
					start = 1'b1;
				end
				PH_ZERO: begin
					if (e.x) begin
						nxt.rad   = RADIX_HEX;
						nxt_phase = PH_ZEROX;
					end else if (e.digit < rad_cur) begin
						take = 1'b1;
					end else begin
						nxt.trail = !e.nul;
						nxt_phase = PH_DONE;
					end
				end
				PH_ZEROX: begin
					if (e.digit < RADIX_HEX) begin
						take = 1'b1;
					end else begin
						nxt.trail = 1'b1;
						nxt_phase = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (e.digit < rad_cur) begin
						take = 1'b1;
					end else begin
						nxt.trail = !e.nul;
						nxt_phase = PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end

		if (start) begin
			if (radix_bad(rad_cur)) begin
				nxt_phase = PH_DONE;
			end else if (e.zero && (rad_cur == RADIX_AUTO || rad_cur == RADIX_HEX)) begin
				nxt.rad   = (rad_cur == RADIX_AUTO) ? RADIX_OCT : rad_cur;
				nxt.acc   = '0;
				nxt.seen  = 1'b1;
				nxt.cons  = e.pos;
				nxt_phase = PH_ZERO;
			end else begin
				nxt.rad = rad_start;
				if (e.digit < rad_start) begin
					take = 1'b1;
				end else begin
					nxt_phase = PH_DONE;
				end
			end
		end

		if (take) begin
			if (!ovf_q) begin
				if (|sum[70:64]) begin
					nxt.ovf = 1'b1;
				end else begin
					nxt.acc = sum[63:0];
				end
			end
			nxt.seen  = 1'b1;
			nxt.cons  = e.pos;
			nxt_phase = PH_DIGITS;
		end

		nxt.zerox = (nxt_phase == PH_ZEROX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			phase_q <= PH_WS;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
			rad_q   <= '0;
			cons_q  <= '0;
			seen_q  <= 1'b0;
			trail_q <= 1'b0;
			long_q  <= 1'b0;
		end else if (pop) begin
			if (e.last) begin
				acc_q   <= '0;
				phase_q <= PH_WS;
				neg_q   <= 1'b0;
				ovf_q   <= 1'b0;
				rad_q   <= '0;
				cons_q  <= '0;
				seen_q  <= 1'b0;
				trail_q <= 1'b0;
				long_q  <= 1'b0;
			end else begin
				acc_q   <= nxt.acc;
				phase_q <= nxt_phase;
				neg_q   <= nxt.neg;
				ovf_q   <= nxt.ovf;
				rad_q   <= nxt.rad;
				cons_q  <= nxt.cons;
				seen_q  <= nxt.seen;
				trail_q <= nxt.trail;
				long_q  <= nxt.too_long;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && e.last) begin
			snap_s1 <= nxt;
		end
	end

	// Stage two settles the early errors and applies the sign.
	logic [VALUE_W-1:0] f_val;
	status_t            f_st;
	logic               f_chk;
	logic               f_trail;
	logic               mag_over;

	always_comb begin
		f_trail  = snap_s1.trail || snap_s1.zerox;
		mag_over = snap_s1.neg ? (snap_s1.acc[63] && |snap_s1.acc[62:0]) : snap_s1.acc[63];
		f_val    = '0;
		f_st     = ST_OK;
		f_chk    = 1'b0;
		if (snap_s1.too_long) begin
			f_st = ST_TOO_LONG;
		end else if (radix_bad(snap_s1.rad) || !snap_s1.seen) begin
			f_st = ST_NO_NUM;
		end else if (cfg.signed_mode && (snap_s1.ovf || mag_over)) begin
			f_st  = ST_OVERFLOW;
			f_val = snap_s1.neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else if (!cfg.signed_mode && snap_s1.ovf) begin
			f_st  = ST_OVERFLOW;
			f_val = '1;
		end else begin
			f_val = snap_s1.neg ? ('0 - snap_s1.acc) : snap_s1.acc;
			if (cfg.strict_mode && f_trail) begin
				f_st = ST_TRAILING;
			end else begin
				f_chk = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			val_s2  <= f_val;
			st_s2   <= f_st;
			chk_s2  <= f_chk;
			cons_s2 <= (f_st == ST_TOO_LONG || f_st == ST_NO_NUM) ? '0 : snap_s1.cons;
		end
	end

	// Output stage: width and bound checks.
	logic               width_bad;
	logic               bound_bad;
	logic [VALUE_W-1:0] v_x, min_x, max_x;

	always_comb begin
		case (cfg.width_select)
			WSEL_8: width_bad = cfg.signed_mode ?
				!(val_s2[63:7] == '0 || val_s2[63:7] == '1) : (val_s2[63:8] != '0);
			WSEL_16: width_bad = cfg.signed_mode ?
				!(val_s2[63:15] == '0 || val_s2[63:15] == '1) : (val_s2[63:16] != '0);
			WSEL_32: width_bad = cfg.signed_mode ?
				!(val_s2[63:31] == '0 || val_s2[63:31] == '1) : (val_s2[63:32] != '0);
			default: width_bad = 1'b0;
		endcase
		v_x       = {val_s2[63] ^ cfg.signed_mode, val_s2[62:0]};
		min_x     = {cfg.bound_min[63] ^ cfg.signed_mode, cfg.bound_min[62:0]};
		max_x     = {cfg.bound_max[63] ^ cfg.signed_mode, cfg.bound_max[62:0]};
		bound_bad = cfg.bounds_enable && ((v_x < min_x) || (v_x > max_x));
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			out_value_q <= val_s2;
			out_cons_q  <= cons_s2;
			out_st_q    <= (chk_s2 && (width_bad || bound_bad)) ? ST_RANGE : st_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= pop && e.last;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	assign result.valid    = out_valid_q;
	assign result.value    = out_value_q;
	assign result.consumed = CONSUMED_W'(out_cons_q);
	assign result.status   = out_st_q;

endmodule

// ===== hw/rtl/ascii_number_parser_top.sv =====
// Top level of the ASCII number parser: configuration registers, front end,
// entry queue and back end. Depends on anp_pkg, anp_if and the anp_ modules.
//
//   channel   role     payload                       accepted when
//   text      sink     text_byte, is_last            text.valid && text.ready
//   result    source   value, consumed, status       result.valid && result.ready
//   cfg       sink     index, data                   cfg.valid (ready is always high)
//
// One text item is taken per cycle while the queue is not full; the back end's
// radix multiply-accumulate handles one byte per cycle unless its result
// pipeline is stalled. Reset clears the field state and loads the register
// defaults. A stalled result holds the back end, and the queue of four
// entries fills before text.ready falls.
module ascii_number_parser_top (
	input  logic         clk,
	input  logic         arst_n,
	anp_byte_if.sink     text,
	anp_result_if.source result,
	anp_cfg_if.sink      cfg
);
	import anp_pkg::*;

	cfg_t   cfg_q;
	entry_t push_entry;
	entry_t pop_entry;
	logic   push, pop, q_full, q_valid;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix         <= RADIX_DEC;
			cfg_q.signed_mode   <= 1'b0;
			cfg_q.width_select  <= 2'd3;
			cfg_q.strict_mode   <= 1'b0;
			cfg_q.bounds_enable <= 1'b0;
			cfg_q.bound_min     <= '0;
			cfg_q.bound_max     <= '1;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_RADIX:     cfg_q.radix         <= cfg.data[RADIX_W-1:0];
				REG_SIGNED:    cfg_q.signed_mode   <= cfg.data[0];
				REG_WIDTH:     cfg_q.width_select  <= cfg.data[1:0];
				REG_STRICT:    cfg_q.strict_mode   <= cfg.data[0];
				REG_BOUNDS_EN: cfg_q.bounds_enable <= cfg.data[0];
				REG_BOUND_MIN: cfg_q.bound_min     <= cfg.data;
				REG_BOUND_MAX: cfg_q.bound_max     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	anp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.radix  (cfg_q.radix),
		.q_full (q_full),
		.push   (push),
		.entry  (push_entry)
	);

	anp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_entry),
		.full   (q_full),
		.pop    (pop),
		.rvalid (q_valid),
		.rdata  (pop_entry)
	);

	anp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.e       (pop_entry),
		.pop     (pop),
		.result  (result)
	);

endmodule
